// File: rtl/core/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the sweep-and-prune projection table.
// ----------------------------------------------------------------------------
`default_nettype none
package spp_pkg;
    localparam int AXES = 3;
    localparam logic [6:0] MARGIN_FACTOR = 7'd100;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AX_X    = 2'd0,
        AX_Y    = 2'd1,
        AX_Z    = 2'd2,
        AX_NONE = 2'd3
    } axis_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_PUT,
        ST_Q_WIN,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_DUP_RD,
        ST_Q_DUP_CHK,
        ST_Q_EMIT,
        ST_Q_NEXT,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: rtl/core/sweep_prune_projection_table_top.sv
// ----------------------------------------------------------------------------
// sweep_prune_projection_table_top
// Three sorted projection lists in one RAM with insert, window query, clear.
// ----------------------------------------------------------------------------
//  group   dir  carries
//  s_*     in   tuser operation; tdata insert and query fields
//  m_*     out  tuser hit; tdata found entry or end word; tlast on end word
//  cfg     in   barrier_thickness write
// Insert: shifts each entry with a lower position one place toward the tail.
// Query: per axis scans every entry of the list; each match is rechecked against
//   earlier entries of that axis for a duplicate before it is emitted.
// One word at a time; m_tready low holds the FSM at each emit. Reset clears
//   fills and barrier, not the RAM.
`default_nettype none
module sweep_prune_projection_table_top
    import spp_pkg::*;
#(
    parameter int ENTRIES_PER_AXIS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // axis, position, axon_id, sphere_id, center_x, center_y, center_z,
    // radius, pad (bits 0..199)
    input  wire logic [199:0] s_tdata,
    // operation
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_axis, hit_position, hit_axon_id, hit_sphere_id, status, pad
    output logic [71:0]       m_tdata,
    // hit
    output logic [0:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);
    localparam int DEPTH = AXES * ENTRIES_PER_AXIS;
    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(ENTRIES_PER_AXIS + 1);
    localparam logic [IW-1:0] FULL = IW'(ENTRIES_PER_AXIS);

    state_t st_reg, st_next;
    logic [15:0] bt_reg;
    logic [IW-1:0] fill_reg [AXES];
    logic [1:0] ax_reg, ax_next;
    logic [31:0] pos_reg;
    logic [15:0] axon_reg, sph_reg;
    logic [31:0] cen_reg [AXES];
    logic [31:0] margin_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic found_reg, found_next;
    logic status_reg;
    logic [31:0] hold_pos_reg;
    logic [15:0] hold_ax_reg, hold_sp_reg;
    logic        out_v_reg, out_hit_reg, out_last_reg, out_status_reg;
    logic [1:0]  out_axis_reg;
    logic [31:0] out_pos_reg;
    logic [15:0] out_axon_reg, out_sph_reg;
    logic [AW-1:0] addr;
    logic          we;
    logic [63:0]   wdata, rdata;
    logic          fill_inc, fill_clr;
    logic          load_hold, set_win;
    logic          emit, emit_last;
    logic [IW-1:0] cur_fill, in_fill;
    logic [31:0]   cen;

    spp_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [AW-1:0] base;
    assign base = AW'(ax_reg) * AW'(ENTRIES_PER_AXIS);

    logic [22:0] bt100;
    logic signed [33:0] lo_w, hi_w;
    assign bt100 = 23'(bt_reg) * 23'(MARGIN_FACTOR);
    assign lo_w = $signed({{2{cen[31]}}, cen}) - $signed({2'b00, margin_reg});
    assign hi_w = $signed({{2{cen[31]}}, cen}) + $signed({2'b00, margin_reg});

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -34'sh080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic rd_in_win;
    assign rd_in_win = ($signed(rdata[31:0]) > lo_reg) && ($signed(rdata[31:0]) <= hi_reg);

    logic out_free;
    assign out_free = !out_v_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE);
    logic take;
    assign take = s_tvalid && s_tready;
    op_t in_op;
    assign in_op = op_t'(s_tuser);
    logic [1:0] in_ax;
    assign in_ax = s_tdata[1:0];

    always_comb begin
        case (ax_reg)
            AX_X: begin
                cur_fill = fill_reg[0];
                cen = cen_reg[0];
            end
            AX_Y: begin
                cur_fill = fill_reg[1];
                cen = cen_reg[1];
            end
            AX_Z: begin
                cur_fill = fill_reg[2];
                cen = cen_reg[2];
            end
            default: begin
                cur_fill = '0;
                cen = '0;
            end
        endcase
    end

    always_comb begin
        case (in_ax)
            AX_X: in_fill = fill_reg[0];
            AX_Y: in_fill = fill_reg[1];
            AX_Z: in_fill = fill_reg[2];
            default: in_fill = '0;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        ax_next = ax_reg;
        i_next = i_reg;
        j_next = j_reg;
        found_next = found_reg;
        addr = base + AW'(i_reg);
        we = 1'b0;
        wdata = rdata;
        fill_inc = 1'b0;
        fill_clr = 1'b0;
        load_hold = 1'b0;
        set_win = 1'b0;
        emit = 1'b0;
        emit_last = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (take) begin
                    unique case (in_op)
                        OP_INSERT: begin
                            if (in_ax != AX_NONE && in_fill != FULL) begin
                                ax_next = in_ax;
                                i_next = in_fill;
                                st_next = ST_INS_RD;
                            end else begin
                                st_next = ST_OUT;
                            end
                        end
                        OP_QUERY: begin
                            ax_next = AX_X;
                            st_next = ST_Q_WIN;
                        end
                        OP_CLEAR: begin
                            fill_clr = 1'b1;
                            st_next = ST_OUT;
                        end
                        OP_NONE: st_next = ST_OUT;
                    endcase
                end
            end
            ST_INS_RD: begin
                if (i_reg == '0) begin
                    st_next = ST_INS_PUT;
                end else begin
                    addr = base + AW'(i_reg - 1'b1);
                    st_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                if ($signed(rdata[31:0]) < $signed(pos_reg)) begin
                    addr = base + AW'(i_reg);
                    we = 1'b1;
                    wdata = rdata;
                    i_next = i_reg - 1'b1;
                    st_next = ST_INS_RD;
                end else begin
                    st_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                addr = base + AW'(i_reg);
                we = 1'b1;
                wdata = {sph_reg, axon_reg, pos_reg};
                fill_inc = 1'b1;
                st_next = ST_OUT;
            end
            ST_Q_WIN: begin
                set_win = 1'b1;
                i_next = '0;
                found_next = 1'b0;
                st_next = ST_Q_RD;
            end
            ST_Q_RD: begin
                if (i_reg == cur_fill) begin
                    st_next = ST_Q_NEXT;
                end else begin
                    addr = base + AW'(i_reg);
                    st_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                if (rd_in_win) begin
                    load_hold = 1'b1;
                    j_next = '0;
                    st_next = ST_Q_DUP_RD;
                end else begin
                    i_next = i_reg + 1'b1;
                    st_next = ST_Q_RD;
                end
            end
            ST_Q_DUP_RD: begin
                if (j_reg == i_reg) begin
                    st_next = ST_Q_EMIT;
                end else begin
                    addr = base + AW'(j_reg);
                    st_next = ST_Q_DUP_CHK;
                end
            end
            ST_Q_DUP_CHK: begin
                if (rd_in_win && rdata[47:32] == hold_ax_reg
                    && rdata[63:48] == hold_sp_reg) begin
                    i_next = i_reg + 1'b1;
                    st_next = ST_Q_RD;
                end else begin
                    j_next = j_reg + 1'b1;
                    st_next = ST_Q_DUP_RD;
                end
            end
            ST_Q_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    found_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    st_next = ST_Q_RD;
                end
            end
            ST_Q_NEXT: begin
                if (!found_reg || ax_reg == AX_Z) begin
                    st_next = ST_OUT;
                end else begin
                    ax_next = ax_reg + 2'd1;
                    st_next = ST_Q_WIN;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            bt_reg <= '0;
            out_v_reg <= 1'b0;
            ax_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            found_reg <= 1'b0;
            for (int k = 0; k < AXES; k++) fill_reg[k] <= '0;
        end else begin
            st_reg <= st_next;
            ax_reg <= ax_next;
            i_reg <= i_next;
            j_reg <= j_next;
            found_reg <= found_next;
            if (cfg_we) bt_reg <= cfg_wdata;
            for (int k = 0; k < AXES; k++) begin
                if (fill_clr) begin
                    fill_reg[k] <= '0;
                end else if (fill_inc && ax_reg == 2'(k)) begin
                    fill_reg[k] <= fill_reg[k] + 1'b1;
                end
            end
            if (emit) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg <= (in_op == OP_INSERT) && (in_ax != AX_NONE) && (in_fill == FULL);
            pos_reg <= s_tdata[33:2];
            axon_reg <= s_tdata[49:34];
            sph_reg <= s_tdata[65:50];
            cen_reg[0] <= s_tdata[97:66];
            cen_reg[1] <= s_tdata[129:98];
            cen_reg[2] <= s_tdata[161:130];
            margin_reg <= 32'(s_tdata[192:162]) + 32'(bt100);
        end
        if (set_win) begin
            lo_reg <= sat(lo_w);
            hi_reg <= sat(hi_w);
        end
        if (load_hold) begin
            hold_pos_reg <= rdata[31:0];
            hold_ax_reg <= rdata[47:32];
            hold_sp_reg <= rdata[63:48];
        end
        if (emit) begin
            out_hit_reg <= !emit_last;
            out_last_reg <= emit_last;
            out_status_reg <= emit_last && status_reg;
            out_axis_reg <= emit_last ? 2'd0 : ax_reg;
            out_pos_reg <= emit_last ? 32'd0 : hold_pos_reg;
            out_axon_reg <= emit_last ? 16'd0 : hold_ax_reg;
            out_sph_reg <= emit_last ? 16'd0 : hold_sp_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser = out_hit_reg;
    assign m_tlast = out_last_reg;
    assign m_tdata = {5'd0, out_status_reg, out_sph_reg, out_axon_reg, out_pos_reg,
                      out_axis_reg};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser));
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[0] <= FULL && fill_reg[1] <= FULL && fill_reg[2] <= FULL);
    a_hit_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast);
    a_status_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66] |-> m_tlast && !m_tuser[0]);
endmodule
`default_nettype wire

// File: rtl/core/spp_ram.sv
// ----------------------------------------------------------------------------
// spp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module spp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: tb/tb_sweep_prune_projection_table_top.sv
// ----------------------------------------------------------------------------
// tb_sweep_prune_projection_table_top
// Self-checking regression of the sweep-and-prune projection table: inserts,
// window queries, clears and ignored words under several barrier settings,
// with random idle on both stream sides, checked against an internal
// model of the three sorted axis lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_sweep_prune_projection_table_top
    import spp_pkg::*;
();

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  pad;
        logic [30:0] radius;
        logic [31:0] cz;
        logic [31:0] cy;
        logic [31:0] cx;
        logic [15:0] sphere;
        logic [15:0] axon;
        logic [31:0] position;
        logic [1:0]  axis;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  axis;
        logic [31:0] position;
        logic [15:0] axon;
        logic [15:0] sphere;
        logic        last;
        logic        status;
    } result_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we = 0;
    logic [15:0]  cfg_wdata = '0;

    sweep_prune_projection_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // model state
    logic signed [31:0] list_pos [3][DEPTH];
    logic [15:0]        list_axon [3][DEPTH];
    logic [15:0]        list_sph [3][DEPTH];
    int                 list_fill [3];
    logic [15:0]        barrier = 0;

    result_t hit_q [$];
    int      errors = 0;
    int      words_seen = 0;
    int      hits_seen = 0;
    int      items_sent = 0;
    bit      quiet = 0;

    initial forever #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 37);
    end

    // the word at this negedge is taken at the next rising edge
    always @(negedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser[0];
            got.axis = m_tdata[1:0];
            got.position = m_tdata[33:2];
            got.axon = m_tdata[49:34];
            got.sphere = m_tdata[65:50];
            got.status = m_tdata[66];
            got.last = m_tlast;
            words_seen++;
            if (got.hit) hits_seen++;
            if (hit_q.size() == 0) begin
                errors++;
                $display("%t unexpected word: actual %h", $time, got);
            end else begin
                want = hit_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%t mismatch: expected %h, actual %h", $time, want, got);
                end
            end
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void queue_word(result_t r);
        hit_q.insert(hit_q.size(), r);
    endfunction

    function automatic void push_end(logic status);
        result_t r;
        r = '0;
        r.last = 1;
        r.status = status;
        queue_word(r);
    endfunction

    function automatic void predict_table(cmd_t c);
        int at, n, found;
        longint margin, ctr, lo, hi, p;
        logic [15:0] seen_ax [DEPTH];
        logic [15:0] seen_sp [DEPTH];
        logic [31:0] ctrs [3];
        bit dup;
        result_t r;
        case (op_t'(c.operation))
            OP_INSERT: begin
                if (c.axis == AX_NONE) begin
                    push_end(0);
                end else if (list_fill[c.axis] >= DEPTH) begin
                    push_end(1);
                end else begin
                    n = list_fill[c.axis];
                    at = 0;
                    while (at < n && list_pos[c.axis][at] >= $signed(c.position)) at++;
                    for (int i = n; i > at; i--) begin
                        list_pos[c.axis][i] = list_pos[c.axis][i-1];
                        list_axon[c.axis][i] = list_axon[c.axis][i-1];
                        list_sph[c.axis][i] = list_sph[c.axis][i-1];
                    end
                    list_pos[c.axis][at] = c.position;
                    list_axon[c.axis][at] = c.axon;
                    list_sph[c.axis][at] = c.sphere;
                    list_fill[c.axis] = n + 1;
                    push_end(0);
                end
            end
            OP_QUERY: begin
                ctrs[0] = c.cx;
                ctrs[1] = c.cy;
                ctrs[2] = c.cz;
                margin = longint'({1'b0, c.radius}) + 100 * longint'({1'b0, barrier});
                for (int a = 0; a < 3; a++) begin
                    ctr = longint'($signed(ctrs[a]));
                    lo = clamp32(ctr - margin);
                    hi = clamp32(ctr + margin);
                    found = 0;
                    for (int i = 0; i < list_fill[a]; i++) begin
                        p = longint'(list_pos[a][i]);
                        if (p > lo && p <= hi) begin
                            dup = 0;
                            for (int j = 0; j < found; j++)
                                if (seen_ax[j] == list_axon[a][i] &&
                                    seen_sp[j] == list_sph[a][i]) dup = 1;
                            if (!dup) begin
                                seen_ax[found] = list_axon[a][i];
                                seen_sp[found] = list_sph[a][i];
                                found++;
                                r = '0;
                                r.hit = 1;
                                r.axis = a[1:0];
                                r.position = list_pos[a][i];
                                r.axon = list_axon[a][i];
                                r.sphere = list_sph[a][i];
                                queue_word(r);
                            end
                        end
                    end
                    if (found == 0) break;
                end
                push_end(0);
            end
            OP_CLEAR: begin
                for (int a = 0; a < 3; a++) list_fill[a] = 0;
                push_end(0);
            end
            default: push_end(0);
        endcase
    endfunction

    task automatic send_word(cmd_t c);
        if (!quiet && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= c.operation;
        s_tdata <= c[199:0];
        do @(negedge aclk); while (!s_tready);
        predict_table(c);
        items_sent++;
        @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (hit_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_barrier(logic [15:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        barrier = v;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    function automatic cmd_t mk_insert(logic [1:0] ax, logic [31:0] p, logic [15:0] id_a,
                                       logic [15:0] id_s);
        cmd_t c;
        c = '0;
        c.operation = OP_INSERT;
        c.axis = ax;
        c.position = p;
        c.axon = id_a;
        c.sphere = id_s;
        return c;
    endfunction

    function automatic cmd_t mk_query(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [30:0] rad);
        cmd_t c;
        c = '0;
        c.operation = OP_QUERY;
        c.cx = x;
        c.cy = y;
        c.cz = z;
        c.radius = rad;
        return c;
    endfunction

    function automatic logic [31:0] near_pos();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 8000)) - 4000) <<< 6;
    endfunction

    task automatic test_directed;
        cmd_t c;
        send_word(mk_insert(AX_X, 32'h7fffffff, 16'hffff, 16'hffff));
        send_word(mk_insert(AX_X, 32'h80000000, 16'h0000, 16'h0000));
        send_word(mk_insert(AX_X, 32'h00000000, 16'h1234, 16'h5678));
        send_word(mk_insert(AX_X, 32'h00000000, 16'h1234, 16'h5678));
        send_word(mk_insert(AX_Y, 32'h00010000, 16'h0001, 16'h0002));
        send_word(mk_insert(AX_Z, 32'hffff0000, 16'h0003, 16'h0004));
        send_word(mk_insert(AX_NONE, 32'h00000005, 16'h00aa, 16'h00bb));
        c = '0;
        c.operation = OP_NONE;
        send_word(c);
        send_word(mk_query(32'd0, 32'h00010000, 32'hffff0000, 31'd0));
        send_word(mk_query(32'd0, 32'h00010000, 32'hffff0000, 31'h7fffffff));
        send_word(mk_query(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff));
        send_word(mk_query(32'h12345678, 32'd0, 32'd0, 31'd1));
        for (int i = 0; i < 18; i++)
            send_word(mk_insert(AX_Y, $urandom, 16'(i % 3), 16'(i % 2)));
        send_word(mk_query(32'd0, 32'd0, 32'd0, 31'h7fffffff));
        c = '0;
        c.operation = OP_CLEAR;
        send_word(c);
        send_word(mk_query(32'd0, 32'd0, 32'd0, 31'h7fffffff));
    endtask

    task automatic test_random(int count);
        cmd_t c;
        int sel;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            quiet = (i >= count / 4 && i < count / 4 + 40);
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                c = mk_insert(2'($urandom_range(0, 2)), near_pos(),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3)),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3)));
                if ($urandom_range(0, 29) == 0) c.axis = AX_NONE;
            end else if (sel < 93) begin
                c = mk_query(near_pos(), near_pos(), near_pos(),
                             ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                                         : 31'($urandom_range(0, 40000)));
            end else if (sel < 97) begin
                c = '0;
                c.operation = OP_CLEAR;
            end else begin
                c = '0;
                c.operation = OP_NONE;
            end
            send_word(c);
        end
        quiet = 0;
    endtask

    initial begin
        for (int a = 0; a < 3; a++) list_fill[a] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        write_barrier(16'hffff);
        test_random(90);
        write_barrier(16'd0);
        test_random(90);
        write_barrier(16'd40);
        test_random(90);
        write_barrier(16'($urandom));
        test_random(60);
        drain();
        $display("covered %0d words in, %0d words out (%0d hits), barrier min/max/mid",
                 items_sent, words_seen, hits_seen);
        if (errors == 0)
            $display("sweep_prune_projection_table_top regression: pass");
        else
            $display("sweep_prune_projection_table_top regression: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("sweep_prune_projection_table_top regression: fail");
        $finish;
    end
endmodule
